// ----- sv/gfed_pkg.sv -----
package gfed_pkg;

	localparam int SAMPLES_PER_FRAME_DEF = 9;
	localparam int AVG_FRAC_BITS_DEF     = 16;

	localparam int SAMPLE_W = 10;
	localparam int MEAN_W   = 10;
	localparam int FILL_W   = 8;
	localparam int SETTLE_W = 4;
	localparam int LIMIT_W  = 10;
	localparam int WEIGHT_W = 17;
	localparam int MARGIN_W = 16;
	localparam int Q16_SH   = 16;

	localparam logic [WEIGHT_W-1:0] Q16_ONE = 17'h10000;

	localparam logic [FILL_W-1:0] FILL_TRIM = 8'd3;
	localparam logic [FILL_W-1:0] FILL_MAX  = 8'd255;

	localparam int QUEUE_DEPTH = 2;

	localparam int OUT_DONE_BIT   = 0;
	localparam int OUT_ACTIVE_BIT = 1;
	localparam int OUT_MEAN_LSB   = 2;
	localparam int OUT_FILL_LSB   = OUT_MEAN_LSB + MEAN_W;
	localparam int OUT_USED_W     = OUT_FILL_LSB + FILL_W;
	localparam int OUT_W          = ((OUT_USED_W + 7) / 8) * 8;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	localparam logic [LIMIT_W-1:0]  RST_DEV_LIMIT   = 10'd10;
	localparam logic [WEIGHT_W-1:0] RST_EMA_WEIGHT  = 17'd655;
	localparam logic [MARGIN_W-1:0] RST_BAND_MARGIN = 16'd6554;
	localparam logic [FILL_W-1:0]   RST_FILL_LIMIT  = 8'd60;
	localparam logic [SETTLE_W-1:0] RST_SETTLE      = 4'd3;

	typedef enum logic [2:0] {
		REG_DEV_LIMIT   = 3'd0,
		REG_EMA_WEIGHT  = 3'd1,
		REG_BAND_MARGIN = 3'd2,
		REG_FILL_LIMIT  = 3'd3,
		REG_SETTLE      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]  deviation_limit;
		logic [WEIGHT_W-1:0] ema_weight;
		logic [MARGIN_W-1:0] band_margin;
		logic [FILL_W-1:0]   fill_limit;
		logic [SETTLE_W-1:0] settle_frames;
	} cfg_t;

	typedef enum logic {
		BK_IDLE,
		BK_EVAL
	} back_state_t;

endpackage

// ----- sv/gfed_front.sv -----
module gfed_front import gfed_pkg::*; #(
	parameter int SAMPLES_PER_FRAME = SAMPLES_PER_FRAME_DEF,
	parameter int IN_W = ((SAMPLES_PER_FRAME_DEF * SAMPLE_W + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [IN_W-1:0] s_tdata,
	input  logic full,
	output logic push,
	output logic [SAMPLES_PER_FRAME*SAMPLE_W+MEAN_W-1:0] push_data
);

	localparam int FRAME_W = SAMPLES_PER_FRAME * SAMPLE_W;
	localparam int SUM_W   = SAMPLE_W + $clog2(SAMPLES_PER_FRAME);
	localparam int DIV_SH  = SUM_W + $clog2(SAMPLES_PER_FRAME);
	localparam int RECIP_W = DIV_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SH) + SAMPLES_PER_FRAME - 1) / SAMPLES_PER_FRAME);
	localparam int PROD_W  = SUM_W + RECIP_W;

	logic               valid_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;
	logic [MEAN_W-1:0]  mean;

	assign push     = valid_s1 && !full;
	assign s_tready = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			frame_s1 <= s_tdata[FRAME_W-1:0];
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
			sum = sum + SUM_W'(frame_s1[i*SAMPLE_W +: SAMPLE_W]);
		end
	end

	// The rounded-up reciprocal is exact for every sum of this width.
	assign prod = PROD_W'(sum) * PROD_W'(RECIP);
	assign mean = prod[DIV_SH +: MEAN_W];

	assign push_data = {mean, frame_s1};

endmodule

// ----- sv/gfed_queue.sv -----
module gfed_queue import gfed_pkg::*; #(
	parameter int WIDTH = SAMPLES_PER_FRAME_DEF * SAMPLE_W + MEAN_W
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/gfed_back.sv -----
module gfed_back import gfed_pkg::*; #(
	parameter int SAMPLES_PER_FRAME = SAMPLES_PER_FRAME_DEF,
	parameter int AVG_FRAC_BITS     = AVG_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_valid,
	input  logic [SAMPLES_PER_FRAME*SAMPLE_W+MEAN_W-1:0] q_data,
	output logic q_pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	localparam int FRAME_W = SAMPLES_PER_FRAME * SAMPLE_W;
	localparam int AVG_W   = MEAN_W + AVG_FRAC_BITS;
	localparam int BAND_W  = AVG_W + WEIGHT_W;
	localparam int GAIN_W  = MEAN_W + WEIGHT_W;
	localparam int UPD_W   = AVG_W + WEIGHT_W + 1;

	back_state_t state_q, state_d;

	logic load_s1;
	logic fire;

	logic [FRAME_W-1:0] frame_s1;
	logic [MEAN_W-1:0]  mean_s1;
	logic [BAND_W-1:0]  lo_s1;
	logic [BAND_W-1:0]  hi_s1;
	logic [BAND_W-1:0]  keep_s1;
	logic [GAIN_W-1:0]  gain_s1;
	logic               dev_s1;

	logic [AVG_W-1:0]   average_q;
	logic [FRAME_W-1:0] ref_q;
	logic               seeded_q;
	logic               flag_q;
	logic [SETTLE_W-1:0] settle_q;
	logic [FILL_W-1:0]  held_q;

	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	logic [WEIGHT_W-1:0] w_sat;
	logic [WEIGHT_W-1:0] one_minus_w;
	logic [WEIGHT_W-1:0] one_minus_bm;
	logic [WEIGHT_W-1:0] one_plus_bm;
	logic                deviates;

	logic [BAND_W-1:0]  lhs;
	logic               in_band;
	logic [UPD_W-1:0]   upd_sum;
	logic [AVG_W-1:0]   upd_avg;
	logic [AVG_W-1:0]   seed_avg;

	logic [AVG_W-1:0]    avg_d;
	logic                seeded_d;
	logic                flag_d;
	logic [SETTLE_W-1:0] settle_d;
	logic [FILL_W-1:0]   held_d;
	logic                ref_load;
	logic                done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) state_d = BK_EVAL;
			end
			BK_EVAL: begin
				if (fire) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		load_s1 = 1'b0;
		fire    = 1'b0;
		case (state_q)
			BK_IDLE: load_s1 = q_valid;
			BK_EVAL: fire = !out_valid_q || m_tready;
			default: begin
				load_s1 = 1'b0;
				fire    = 1'b0;
			end
		endcase
	end

	assign q_pop = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign w_sat        = (cfg.ema_weight > Q16_ONE) ? Q16_ONE : cfg.ema_weight;
	assign one_minus_w  = Q16_ONE - w_sat;
	assign one_minus_bm = Q16_ONE - WEIGHT_W'(cfg.band_margin);
	assign one_plus_bm  = Q16_ONE + WEIGHT_W'(cfg.band_margin);

	always_comb begin
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [SAMPLE_W-1:0] d;
		deviates = 1'b0;
		for (int i = 0; i < SAMPLES_PER_FRAME; i++) begin
			a = q_data[i*SAMPLE_W +: SAMPLE_W];
			b = ref_q[i*SAMPLE_W +: SAMPLE_W];
			d = (a > b) ? a - b : b - a;
			if (d > cfg.deviation_limit) deviates = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			frame_s1 <= q_data[FRAME_W-1:0];
			mean_s1  <= q_data[FRAME_W +: MEAN_W];
			lo_s1    <= BAND_W'(average_q) * BAND_W'(one_minus_bm);
			hi_s1    <= BAND_W'(average_q) * BAND_W'(one_plus_bm);
			keep_s1  <= BAND_W'(average_q) * BAND_W'(one_minus_w);
			gain_s1  <= GAIN_W'(q_data[FRAME_W +: MEAN_W]) * GAIN_W'(w_sat);
			dev_s1   <= deviates;
		end
	end

	assign lhs      = BAND_W'({mean_s1, {(AVG_FRAC_BITS + Q16_SH){1'b0}}});
	assign in_band  = (lhs >= lo_s1) && (lhs <= hi_s1);
	assign upd_sum  = UPD_W'(keep_s1) + (UPD_W'(gain_s1) << AVG_FRAC_BITS);
	assign upd_avg  = upd_sum[Q16_SH +: AVG_W];
	assign seed_avg = {mean_s1, {AVG_FRAC_BITS{1'b0}}};

	always_comb begin
		avg_d    = average_q;
		seeded_d = seeded_q;
		flag_d   = flag_q;
		settle_d = settle_q;
		held_d   = (held_q != FILL_MAX) ? held_q + 1'b1 : held_q;
		ref_load = 1'b0;
		done     = 1'b0;

		if (!seeded_q) begin
			avg_d    = seed_avg;
			ref_load = 1'b1;
			seeded_d = 1'b1;
		end else if (in_band) begin
			if (flag_q) begin
				settle_d = cfg.settle_frames;
				flag_d   = 1'b0;
			end
			if (dev_s1) avg_d = upd_avg;
		end else begin
			flag_d = 1'b1;
		end

		if (settle_d != '0) begin
			settle_d = settle_d - 1'b1;
			if (settle_d == '0) done = 1'b1;
		end

		if (!done) begin
			if (!flag_d && settle_d == '0 && held_d > FILL_TRIM) held_d = FILL_TRIM;
			if (held_d > cfg.fill_limit) begin
				avg_d    = seed_avg;
				ref_load = 1'b1;
				seeded_d = 1'b0;
				flag_d   = 1'b0;
				settle_d = '0;
				held_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_q <= '0;
			seeded_q  <= 1'b0;
			flag_q    <= 1'b0;
			settle_q  <= '0;
			held_q    <= '0;
		end else if (fire) begin
			average_q <= avg_d;
			seeded_q  <= seeded_d;
			flag_q    <= flag_d;
			settle_q  <= settle_d;
			held_q    <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ref_load) begin
			ref_q <= frame_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= OUT_W'({held_d, mean_s1, flag_d, done});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- sv/gesture_frame_event_detector.sv -----
// Gesture frame event detector.
// Frames enter on the s_ stream channel, one frame of sensor samples per
// transaction, and each frame gives exactly one result transaction on the m_
// stream channel in the same order. A result carries the frame mean, the
// gesture flag, a single-result gesture_done marker and the fill count.
// The front end registers the frame and forms the mean with a reciprocal
// multiply, then writes it into a two-entry queue. The back end takes one
// queued frame at a time in two steps: the first forms the band and average
// products, the second updates the detector state and loads the output
// register once the previous result has left it. A result passes through the
// front register, the queue, the back-end stage registers and the output
// register. When the receiver stalls, the result waits in the output
// register, the queue fills, and s_tready drops once the front register is
// also held. An asynchronous reset on arst_n empties the queue and the
// output register, clears the detector state, and restores the configuration
// reset values. The user writes configuration registers through the APB port
// only while idle; the block itself leaves this unchecked.
module gesture_frame_event_detector import gfed_pkg::*; #(
	parameter int SAMPLES_PER_FRAME = SAMPLES_PER_FRAME_DEF,
	parameter int AVG_FRAC_BITS     = AVG_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// sample_0, sample_1, ... each SAMPLE_W bits, then zero padding.
	input  logic [((SAMPLES_PER_FRAME*SAMPLE_W+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// gesture_done, gesture_active, frame_mean, fill_count, then zero padding.
	output logic [OUT_W-1:0] m_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic pready
);

	localparam int IN_W    = ((SAMPLES_PER_FRAME * SAMPLE_W + 7) / 8) * 8;
	localparam int ENTRY_W = SAMPLES_PER_FRAME * SAMPLE_W + MEAN_W;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic               push;
	logic               full;
	logic [ENTRY_W-1:0] push_data;
	logic               pop;
	logic               not_empty;
	logic [ENTRY_W-1:0] pop_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deviation_limit <= RST_DEV_LIMIT;
			cfg_q.ema_weight      <= RST_EMA_WEIGHT;
			cfg_q.band_margin     <= RST_BAND_MARGIN;
			cfg_q.fill_limit      <= RST_FILL_LIMIT;
			cfg_q.settle_frames   <= RST_SETTLE;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DEV_LIMIT:   cfg_q.deviation_limit <= pwdata[LIMIT_W-1:0];
				REG_EMA_WEIGHT:  cfg_q.ema_weight      <= pwdata[WEIGHT_W-1:0];
				REG_BAND_MARGIN: cfg_q.band_margin     <= pwdata[MARGIN_W-1:0];
				REG_FILL_LIMIT:  cfg_q.fill_limit      <= pwdata[FILL_W-1:0];
				REG_SETTLE:      cfg_q.settle_frames   <= pwdata[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEV_LIMIT:   prdata = CFG_DW'(cfg_q.deviation_limit);
			REG_EMA_WEIGHT:  prdata = CFG_DW'(cfg_q.ema_weight);
			REG_BAND_MARGIN: prdata = CFG_DW'(cfg_q.band_margin);
			REG_FILL_LIMIT:  prdata = CFG_DW'(cfg_q.fill_limit);
			REG_SETTLE:      prdata = CFG_DW'(cfg_q.settle_frames);
			default:         prdata = '0;
		endcase
	end

	gfed_front #(
		.SAMPLES_PER_FRAME(SAMPLES_PER_FRAME),
		.IN_W(IN_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.full(full),
		.push(push),
		.push_data(push_data)
	);

	gfed_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.pop_data(pop_data)
	);

	gfed_back #(
		.SAMPLES_PER_FRAME(SAMPLES_PER_FRAME),
		.AVG_FRAC_BITS(AVG_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(not_empty),
		.q_data(pop_data),
		.q_pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ----- sv/gfed_checker.sv -----
module gfed_checker import gfed_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic pready
);

	// A stalled result transaction keeps its valid and its data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// A completed countdown never coincides with a re-seed, so the count is nonzero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_DONE_BIT] |-> m_tdata[OUT_FILL_LSB +: FILL_W] != '0)
		else $error("gesture done with empty fill count");

	// An active gesture survives only frames that did not re-seed.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_ACTIVE_BIT] |-> m_tdata[OUT_FILL_LSB +: FILL_W] != '0)
		else $error("active gesture with empty fill count");

endmodule

bind gesture_frame_event_detector gfed_checker u_gfed_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.pready(pready)
);

// ----- tb/sv/gesture_frame_event_detector_tb.sv -----
`timescale 1ns / 1ps

module gesture_frame_event_detector_tb;
	import gfed_pkg::*;

	localparam int NSAMP       = SAMPLES_PER_FRAME_DEF;
	localparam int FRAME_W     = NSAMP * SAMPLE_W;
	localparam int S_TDATA_W   = ((FRAME_W + 7) / 8) * 8;
	localparam int AVG_W       = MEAN_W + AVG_FRAC_BITS_DEF;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
	localparam int TAIL_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic [NSAMP-1:0][SAMPLE_W-1:0] frame_t;

	typedef struct packed {
		logic   hold;
		frame_t samples;
	} pending_frame_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill_count;
		logic [MEAN_W-1:0] frame_mean;
		logic              gesture_active;
		logic              gesture_done;
	} gesture_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	pending_frame_t  pending_frames[$];
	gesture_result_t predicted_results[$];

	cfg_t shadow_cfg = '{RST_DEV_LIMIT, RST_EMA_WEIGHT, RST_BAND_MARGIN, RST_FILL_LIMIT,
		RST_SETTLE};
	logic [AVG_W-1:0]    ema_level = '0;
	frame_t              baseline_frame = '0;
	logic                primed = 1'b0;
	logic                in_gesture = 1'b0;
	logic [SETTLE_W-1:0] settle_left = '0;
	logic [FILL_W-1:0]   held_frames = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int frames_sent = 0;
	int results_checked = 0;
	int done_pulses = 0;
	int reseeds = 0;
	int settings_used = 1;
	int cycles = 0;

	gesture_frame_event_detector u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic gesture_result_t evaluate_frame(input frame_t f);
		int total;
		logic [MEAN_W-1:0] mean;
		logic [SAMPLE_W-1:0] gap;
		logic [63:0] scaled, low_edge, high_edge;
		logic [WEIGHT_W-1:0] w;
		logic moved, done;
		gesture_result_t r;
		total = 0;
		for (int i = 0; i < NSAMP; i++) total += f[i];
		mean = MEAN_W'(total / NSAMP);
		done = 1'b0;
		if (held_frames != FILL_MAX) held_frames++;
		scaled = 64'(mean) << (AVG_FRAC_BITS_DEF + Q16_SH);
		low_edge = 64'(ema_level) * (64'(Q16_ONE) - 64'(shadow_cfg.band_margin));
		high_edge = 64'(ema_level) * (64'(Q16_ONE) + 64'(shadow_cfg.band_margin));
		if (!primed) begin
			ema_level = {mean, {AVG_FRAC_BITS_DEF{1'b0}}};
			baseline_frame = f;
			primed = 1'b1;
		end else if (scaled >= low_edge && scaled <= high_edge) begin
			if (in_gesture) begin
				settle_left = shadow_cfg.settle_frames;
				in_gesture = 1'b0;
			end
			moved = 1'b0;
			for (int i = 0; i < NSAMP; i++) begin
				gap = (f[i] > baseline_frame[i]) ? f[i] - baseline_frame[i]
					: baseline_frame[i] - f[i];
				if (gap > shadow_cfg.deviation_limit) moved = 1'b1;
			end
			if (moved) begin
				w = (shadow_cfg.ema_weight > Q16_ONE) ? Q16_ONE : shadow_cfg.ema_weight;
				ema_level = AVG_W'((64'(ema_level) * (64'(Q16_ONE) - 64'(w))
					+ (64'(mean) << AVG_FRAC_BITS_DEF) * 64'(w)) >> Q16_SH);
			end
		end else if (!in_gesture) begin
			in_gesture = 1'b1;
		end
		if (settle_left != '0) begin
			settle_left--;
			if (settle_left == '0) begin
				done = 1'b1;
				done_pulses++;
			end
		end
		if (!done) begin
			if (!in_gesture && settle_left == '0 && held_frames > FILL_TRIM)
				held_frames = FILL_TRIM;
			if (held_frames > shadow_cfg.fill_limit) begin
				ema_level = {mean, {AVG_FRAC_BITS_DEF{1'b0}}};
				baseline_frame = f;
				primed = 1'b0;
				in_gesture = 1'b0;
				settle_left = '0;
				held_frames = '0;
				reseeds++;
			end
		end
		r.gesture_done = done;
		r.gesture_active = in_gesture;
		r.frame_mean = mean;
		r.fill_count = held_frames;
		return r;
	endfunction

	function automatic frame_t noisy_frame(input int center, input int amp);
		frame_t f;
		int v;
		for (int i = 0; i < NSAMP; i++) begin
			v = center + int'($urandom_range(2 * amp)) - amp;
			f[i] = SAMPLE_W'((v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v);
		end
		return f;
	endfunction

	// Well-formed traffic: quiet stretches around the current average, gestures
	// well away from it, and the odd frame of pure noise.
	task automatic add_activity(input int count, input int gesture_max);
		int level, run, amp, far;
		frame_t f;
		level = int'(ema_level >> AVG_FRAC_BITS_DEF);
		while (count > 0) begin
			case ($urandom_range(9))
				0: begin
					for (int i = 0; i < NSAMP; i++) f[i] = SAMPLE_W'($urandom_range(SAMPLE_MAX));
					pending_frames.push_back('{1'b0, f});
					count--;
				end
				1, 2, 3: begin
					run = $urandom_range(gesture_max, 1);
					far = (level > 511) ? level - 60 - int'($urandom_range(300))
						: level + 60 + int'($urandom_range(300));
					repeat (run) pending_frames.push_back('{1'b0, noisy_frame(far, 8)});
					count -= run;
				end
				default: begin
					run = $urandom_range(12, 1);
					amp = $urandom_range(1) ? int'($urandom_range(3)) : int'($urandom_range(40));
					repeat (run) pending_frames.push_back('{1'b0, noisy_frame(level, amp)});
					count -= run;
				end
			endcase
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_frames.size() != 0 || s_tvalid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
		logic [CFG_DW-1:0] stored;
		stored = '0;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DEV_LIMIT: begin
				shadow_cfg.deviation_limit = value[LIMIT_W-1:0];
				stored = CFG_DW'(shadow_cfg.deviation_limit);
			end
			REG_EMA_WEIGHT: begin
				shadow_cfg.ema_weight = value[WEIGHT_W-1:0];
				stored = CFG_DW'(shadow_cfg.ema_weight);
			end
			REG_BAND_MARGIN: begin
				shadow_cfg.band_margin = value[MARGIN_W-1:0];
				stored = CFG_DW'(shadow_cfg.band_margin);
			end
			REG_FILL_LIMIT: begin
				shadow_cfg.fill_limit = value[FILL_W-1:0];
				stored = CFG_DW'(shadow_cfg.fill_limit);
			end
			REG_SETTLE: begin
				shadow_cfg.settle_frames = value[SETTLE_W-1:0];
				stored = CFG_DW'(shadow_cfg.settle_frames);
			end
			default: ;
		endcase
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== stored) begin
			$error("Register %s read back: expected %0d, actual %0d", idx.name(), stored, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int dev, input int weight, input int margin,
		input int fill, input int settle);
		write_reg(REG_DEV_LIMIT, CFG_DW'(dev));
		write_reg(REG_EMA_WEIGHT, CFG_DW'(weight));
		write_reg(REG_BAND_MARGIN, CFG_DW'(margin));
		write_reg(REG_FILL_LIMIT, CFG_DW'(fill));
		write_reg(REG_SETTLE, CFG_DW'(settle));
		settings_used++;
	endtask

	task automatic set_pace(input int send_idle, input int recv_stall);
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
	endtask

	always @(posedge clk or negedge arst_n) begin : frame_driver
		pending_frame_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted_results.push_back(evaluate_frame(s_tdata[FRAME_W-1:0]));
				frames_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_frames.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if ((pending_frames[0].hold && predicted_results.size() != 0)
					|| $urandom_range(99) < send_idle_pct) begin
					s_tvalid <= 1'b0;
				end else begin
					nxt = pending_frames.pop_front();
					s_tdata <= S_TDATA_W'(nxt.samples);
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		gesture_result_t seen, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata[OUT_USED_W-1:0];
				if (predicted_results.size() == 0) begin
					$error("Result transaction with no frame outstanding, m_tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = predicted_results.pop_front();
					results_checked++;
					if (seen.gesture_done !== want.gesture_done) begin
						$error("gesture_done: expected %0d, actual %0d",
							want.gesture_done, seen.gesture_done);
						mismatches++;
					end
					if (seen.gesture_active !== want.gesture_active) begin
						$error("gesture_active: expected %0d, actual %0d",
							want.gesture_active, seen.gesture_active);
						mismatches++;
					end
					if (seen.frame_mean !== want.frame_mean) begin
						$error("frame_mean: expected %0d, actual %0d",
							want.frame_mean, seen.frame_mean);
						mismatches++;
					end
					if (seen.fill_count !== want.fill_count) begin
						$error("fill_count: expected %0d, actual %0d",
							want.fill_count, seen.fill_count);
						mismatches++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		frame_t f;
		int level, far;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings; the band around a seed of 100 is 90 to 110.
		pending_frames.push_back('{1'b0, noisy_frame(100, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(111, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(110, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(90, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(89, 0)});
		wait_idle();

		// A quarter margin puts both band edges exactly on 75 and 125.
		configure(SAMPLE_MAX, 655, 16384, 60, 0);
		pending_frames.push_back('{1'b0, noisy_frame(125, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(126, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(75, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(74, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(100, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(0, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(SAMPLE_MAX, 0)});
		for (int i = 0; i < NSAMP; i++) f[i] = (i % 2) ? 10'h2AA : 10'h155;
		pending_frames.push_back('{1'b0, f});
		pending_frames.push_back('{1'b0, ~f});
		pending_frames.push_back('{1'b0, noisy_frame(100, 0)});
		wait_idle();

		configure(0, 65536, 6554, 3, 15);
		f = noisy_frame(100, 0);
		f[0] = 10'd101;
		pending_frames.push_back('{1'b0, f});
		pending_frames.push_back('{1'b0, noisy_frame(105, 0)});
		wait_idle();

		configure(0, 131071, 6554, 255, 1);
		pending_frames.push_back('{1'b0, noisy_frame(108, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(SAMPLE_MAX, 0)});
		pending_frames.push_back('{1'b0, noisy_frame(108, 0)});
		wait_idle();

		configure(10, 655, 6554, 60, 3);
		set_pace(0, 0);
		add_activity(40, 20);
		pending_frames.push_back('{1'b1, noisy_frame(int'(ema_level >> AVG_FRAC_BITS_DEF), 2)});
		add_activity(40, 20);
		wait_idle();

		configure(0, 65536, 65535, 3, 15);
		set_pace(46, 0);
		add_activity(60, 8);
		wait_idle();

		configure(SAMPLE_MAX, 0, 0, 10, 1);
		set_pace(0, 46);
		add_activity(55, 12);
		wait_idle();

		configure(20, 131071, 3000, 2, 0);
		set_pace(8, 8);
		add_activity(55, 10);
		wait_idle();

		// One gesture long enough to saturate the fill count.
		configure(5, 32768, 13000, 255, 7);
		set_pace(46, 0);
		level = int'(ema_level >> AVG_FRAC_BITS_DEF);
		far = (level > 511) ? level - 300 : level + 300;
		repeat (260) pending_frames.push_back('{1'b0, noisy_frame(far, 5)});
		add_activity(30, 30);
		wait_idle();

		repeat (3) begin
			configure($urandom_range(SAMPLE_MAX), $urandom_range(65536), $urandom_range(65535),
				$urandom_range(255, 3), $urandom_range(15, 1));
			case ($urandom_range(3))
				0: set_pace(0, 0);
				1: set_pace(46, 0);
				2: set_pace(0, 46);
				default: set_pace(8, 8);
			endcase
			add_activity(30, 25);
			pending_frames.push_back('{1'b1,
				noisy_frame(int'(ema_level >> AVG_FRAC_BITS_DEF), 2)});
			add_activity(30, 25);
			wait_idle();
		end

		$display("Sent %0d frames under %0d register settings and checked %0d results.",
			frames_sent, settings_used, results_checked);
		$display("The run held %0d gesture_done pulses and %0d re-seeds.", done_pulses, reseeds);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/gfed_pkg.sv
sv/gfed_front.sv
sv/gfed_queue.sv
sv/gfed_back.sv
sv/gesture_frame_event_detector.sv
sv/gfed_checker.sv
tb/sv/gesture_frame_event_detector_tb.sv
